### rtl/qenc_pkg.sv
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared types and constants for the quadrature encoder position unit.
// ----------------------------------------------------------------------------
package qenc_pkg;

	// Internal counter width; the result field stays 16 bits
	localparam int POS_WIDTH = 16;

	// Wide enough that limit +/- step and count +/- step never overflow
	localparam int CALC_W = ((POS_WIDTH > 16) ? POS_WIDTH : 16) + 2;

	localparam int CFG_IDX_W = 2;

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic signed [CALC_W-1:0]    calc_t;

	localparam calc_t POS_HI = calc_t'({1'b0, {(POS_WIDTH-1){1'b1}}});
	localparam calc_t POS_LO = calc_t'(-POS_HI - calc_t'(1));

	// Channel codes
	localparam logic CHAN_A = 1'b0;
	localparam logic CHAN_B = 1'b1;

	// Pin level patterns: bit0 = A, bit1 = B
	localparam logic [1:0] PINS_BOTH   = 2'b11;
	localparam logic [1:0] PINS_A_ONLY = 2'b01;
	localparam logic [1:0] PINS_B_ONLY = 2'b10;

	typedef enum logic [1:0] {
		MOVE_NONE = 2'd0,
		MOVE_UP   = 2'd1,
		MOVE_DOWN = 2'd2
	} move_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_LIMIT  = 2'd0,
		REG_HIGH_LIMIT = 2'd1,
		REG_STEP_SIZE  = 2'd2
	} reg_idx_t;

	localparam logic signed [15:0] LOW_LIMIT_RST  = 16'sd0;
	localparam logic signed [15:0] HIGH_LIMIT_RST = 16'sd32767;
	localparam logic [14:0]        STEP_SIZE_RST  = 15'd1;

	typedef struct packed {
		logic signed [15:0] low_limit;
		logic signed [15:0] high_limit;
		logic [14:0]        step_size;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [1:0] pin_levels;
	} evt_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic [1:0]         movement;
	} res_t;

endpackage

### rtl/qenc_ifs.sv
// ----------------------------------------------------------------------------
// qenc_ifs
// Valid/ready channel interfaces: encoder events, results, register writes.
// ----------------------------------------------------------------------------
interface qenc_evt_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [1:0] pin_levels;

	modport source (output valid, command, pin_levels, input ready);
	modport sink   (input valid, command, pin_levels, output ready);
endinterface

interface qenc_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] position;
	logic [1:0]         movement;

	modport source (output valid, position, movement, input ready);
	modport sink   (input valid, position, movement, output ready);
endinterface

interface qenc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [qenc_pkg::CFG_IDX_W-1:0]     index;
	logic [15:0]                        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/qenc_cfg_regs.sv
// ----------------------------------------------------------------------------
// qenc_cfg_regs
// Limit and step registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module qenc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [qenc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                    wr_data,
	output qenc_pkg::cfg_t                 cfg
);

	qenc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit  <= qenc_pkg::LOW_LIMIT_RST;
			cfg_q.high_limit <= qenc_pkg::HIGH_LIMIT_RST;
			cfg_q.step_size  <= qenc_pkg::STEP_SIZE_RST;
		end else if (wr_en) begin
			case (qenc_pkg::reg_idx_t'(wr_index))
				qenc_pkg::REG_LOW_LIMIT:  cfg_q.low_limit  <= $signed(wr_data);
				qenc_pkg::REG_HIGH_LIMIT: cfg_q.high_limit <= $signed(wr_data);
				qenc_pkg::REG_STEP_SIZE:  cfg_q.step_size  <= wr_data[14:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/qenc_update.sv
// ----------------------------------------------------------------------------
// qenc_update
// Arming flags and clamped position counter; computes the result of one event.
// ----------------------------------------------------------------------------
module qenc_update (
	input  logic           clk,
	input  logic           arst_n,
	input  qenc_pkg::cfg_t cfg,
	input  qenc_pkg::evt_t evt,
	input  logic           fire,
	output qenc_pkg::res_t res
);

	logic           up_armed_q;
	logic           down_armed_q;
	qenc_pkg::pos_t count_q;

	logic            up_armed_d;
	logic            down_armed_d;
	qenc_pkg::calc_t count_w;
	qenc_pkg::calc_t hi_w;
	qenc_pkg::calc_t lo_w;
	qenc_pkg::calc_t step_w;
	qenc_pkg::calc_t moved_w;
	qenc_pkg::calc_t fit_w;
	qenc_pkg::move_t move;

	assign count_w = qenc_pkg::calc_t'(count_q);
	assign hi_w    = qenc_pkg::calc_t'(cfg.high_limit);
	assign lo_w    = qenc_pkg::calc_t'(cfg.low_limit);
	assign step_w  = qenc_pkg::calc_t'({1'b0, cfg.step_size});

	always_comb begin
		up_armed_d   = up_armed_q;
		down_armed_d = down_armed_q;
		moved_w      = count_w;
		move         = qenc_pkg::MOVE_NONE;
		if (evt.command == qenc_pkg::CHAN_A) begin
			if (evt.pin_levels == qenc_pkg::PINS_BOTH && up_armed_q) begin
				// up move checks only the high limit
				moved_w      = (count_w <= hi_w - step_w) ? count_w + step_w : hi_w;
				up_armed_d   = 1'b0;
				down_armed_d = 1'b0;
				move         = qenc_pkg::MOVE_UP;
			end else if (evt.pin_levels == qenc_pkg::PINS_A_ONLY) begin
				down_armed_d = 1'b1;
			end
		end else begin
			if (evt.pin_levels == qenc_pkg::PINS_BOTH && down_armed_q) begin
				moved_w      = (count_w >= lo_w + step_w) ? count_w - step_w : lo_w;
				up_armed_d   = 1'b0;
				down_armed_d = 1'b0;
				move         = qenc_pkg::MOVE_DOWN;
			end else if (evt.pin_levels == qenc_pkg::PINS_B_ONLY) begin
				up_armed_d = 1'b1;
			end
		end
	end

	// saturate to the counter's own range
	always_comb begin
		if (moved_w > qenc_pkg::POS_HI) begin
			fit_w = qenc_pkg::POS_HI;
		end else if (moved_w < qenc_pkg::POS_LO) begin
			fit_w = qenc_pkg::POS_LO;
		end else begin
			fit_w = moved_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_armed_q   <= 1'b0;
			down_armed_q <= 1'b0;
			count_q      <= '0;
		end else if (fire) begin
			up_armed_q   <= up_armed_d;
			down_armed_q <= down_armed_d;
			count_q      <= fit_w[qenc_pkg::POS_WIDTH-1:0];
		end
	end

	assign res.position = $signed(fit_w[15:0]);
	assign res.movement = move;

endmodule

### rtl/quadrature_encoder_clamped_position_unit.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_clamped_position_unit
// Rotary encoder decoder with half-detent arming and a clamped position count.
// ----------------------------------------------------------------------------
//  Port  Dir   Payload                         Beat
//  evt   sink  command, pin_levels             one pin-change event
//  res   src   position, movement              one result per event
//  cfg   sink  index, data                     one register write
//
//  One event per cycle sustained while res is ready; an evt beat passes the
//  event register and then the result register before its res beat.
//  The throughput is set by the combinational state update between the event
//  register and the result register.
//  arst_n clears the flags, the count and both stage valids; limits and step
//  return to their defaults. cfg is always ready.
//  A stalled res holds its beat; evt keeps flowing until both stages are full.
// ----------------------------------------------------------------------------
module quadrature_encoder_clamped_position_unit (
	input  logic       clk,
	input  logic       arst_n,
	qenc_evt_if.sink   evt,
	qenc_res_if.source res,
	qenc_cfg_if.sink   cfg
);

	qenc_pkg::cfg_t cfg_regs;
	qenc_pkg::evt_t evt_s1;
	logic           valid_s1;
	qenc_pkg::res_t res_next;
	qenc_pkg::res_t res_q;
	logic           res_valid_q;
	logic           out_adv;
	logic           fire;

	assign cfg.ready = 1'b1;

	qenc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	assign out_adv   = !res_valid_q || res.ready;
	assign fire      = valid_s1 && out_adv;
	assign evt.ready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1.command    <= evt.command;
			evt_s1.pin_levels <= evt.pin_levels;
		end
	end

	qenc_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_regs),
		.evt    (evt_s1),
		.fire   (fire),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.position = res_q.position;
	assign res.movement = res_q.movement;

endmodule

### rtl/qenc_checker.sv
// ----------------------------------------------------------------------------
// qenc_checker
// Port-level checks on the encoder position unit, bound to the top level.
// ----------------------------------------------------------------------------
module qenc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_position,
	input logic [1:0]  res_movement,
	input logic        cfg_ready
);

	// back-pressure on events only once the result side is stalled
	a_evt_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> (res_valid && !res_ready))
		else $error("evt not ready while result side can advance");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_position)
		&& $stable(res_movement)))
		else $error("stalled result beat changed");

	a_move_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_movement == qenc_pkg::MOVE_NONE
		|| res_movement == qenc_pkg::MOVE_UP || res_movement == qenc_pkg::MOVE_DOWN))
		else $error("illegal movement code");

	// an accepted event with an empty output side raises res valid via both stage registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_ready && !res_valid) |-> ##2 res_valid)
		else $error("result missing after event");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind quadrature_encoder_clamped_position_unit qenc_checker u_qenc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_position (res.position),
	.res_movement (res.movement),
	.cfg_ready    (cfg.ready)
);

### verif/tb_quadrature_encoder_clamped_position_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_clamped_position_unit
// Self-checking bench for the encoder position unit. Pin-change events are
// pushed through the event channel with random gaps while the result side
// stalls at random. An internal model of the arming flags and the clamped
// count predicts every result beat, which is compared field by field.
// Directed checks cover idle pin patterns, full detents, full-scale steps,
// counts outside the limits, inverted limits and a zero step. Random traffic
// then runs under several limit and step settings.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_clamped_position_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PHASE_ITEMS    = 150;
	localparam int MAX_REPORTS    = 100;

	// not a register: writes to it must be dropped
	localparam logic [qenc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	always #1 clk = ~clk;

	qenc_evt_if evt_bus ();
	qenc_res_if res_bus ();
	qenc_cfg_if cfg_bus ();

	quadrature_encoder_clamped_position_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	// shadow of the block state
	qenc_pkg::cfg_t shadow_cfg;
	logic           arm_up;
	logic           arm_down;
	qenc_pkg::pos_t enc_count;

	qenc_pkg::res_t pending_results[$];
	int             fault_cnt = 0;
	bit             no_gaps = 1'b0;

	function automatic qenc_pkg::res_t advance_encoder(input logic cmd,
			input logic [1:0] pins);
		longint          lo;
		longint          hi;
		longint          stp;
		longint          nxt;
		qenc_pkg::move_t mv;
		qenc_pkg::res_t  out;
		lo  = longint'($signed(shadow_cfg.low_limit));
		hi  = longint'($signed(shadow_cfg.high_limit));
		stp = longint'(shadow_cfg.step_size);
		nxt = longint'(enc_count);
		mv  = qenc_pkg::MOVE_NONE;
		if (cmd == qenc_pkg::CHAN_A) begin
			if (pins == qenc_pkg::PINS_BOTH && arm_up) begin
				nxt = (nxt <= hi - stp) ? nxt + stp : hi;
				arm_up   = 1'b0;
				arm_down = 1'b0;
				mv       = qenc_pkg::MOVE_UP;
			end else if (pins == qenc_pkg::PINS_A_ONLY) begin
				arm_down = 1'b1;
			end
		end else begin
			if (pins == qenc_pkg::PINS_BOTH && arm_down) begin
				nxt = (nxt >= lo + stp) ? nxt - stp : lo;
				arm_up   = 1'b0;
				arm_down = 1'b0;
				mv       = qenc_pkg::MOVE_DOWN;
			end else if (pins == qenc_pkg::PINS_B_ONLY) begin
				arm_up = 1'b1;
			end
		end
		// counter width saturation
		if (nxt > longint'(qenc_pkg::POS_HI))
			nxt = longint'(qenc_pkg::POS_HI);
		if (nxt < longint'(qenc_pkg::POS_LO))
			nxt = longint'(qenc_pkg::POS_LO);
		enc_count    = qenc_pkg::pos_t'(nxt);
		out.position = 16'(nxt);
		out.movement = mv;
		return out;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_event(input logic cmd, input logic [1:0] pins);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_bus.valid      <= 1'b1;
		evt_bus.command    <= cmd;
		evt_bus.pin_levels <= pins;
		do @(posedge clk); while (!evt_bus.ready);
		pending_results.push_back(advance_encoder(cmd, pins));
	endtask

	// drop valid and hold until every outstanding beat has come back
	task automatic wait_drained();
		evt_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [qenc_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		wait_drained();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			qenc_pkg::REG_LOW_LIMIT:  shadow_cfg.low_limit  = value;
			qenc_pkg::REG_HIGH_LIMIT: shadow_cfg.high_limit = value;
			qenc_pkg::REG_STEP_SIZE:  shadow_cfg.step_size  = value[14:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] stp);
		write_reg(qenc_pkg::REG_LOW_LIMIT, lo);
		write_reg(qenc_pkg::REG_HIGH_LIMIT, hi);
		write_reg(qenc_pkg::REG_STEP_SIZE, stp);
	endtask

	task automatic detent_up();
		send_event(qenc_pkg::CHAN_B, qenc_pkg::PINS_B_ONLY);
		send_event(qenc_pkg::CHAN_A, qenc_pkg::PINS_BOTH);
	endtask

	task automatic detent_down();
		send_event(qenc_pkg::CHAN_A, qenc_pkg::PINS_A_ONLY);
		send_event(qenc_pkg::CHAN_B, qenc_pkg::PINS_BOTH);
	endtask

	// both pins low, unarmed both-high edges, and patterns that match no rule
	task automatic test_no_rule_events();
		send_event(qenc_pkg::CHAN_A, 2'b00);
		send_event(qenc_pkg::CHAN_B, 2'b00);
		send_event(qenc_pkg::CHAN_A, qenc_pkg::PINS_BOTH);
		send_event(qenc_pkg::CHAN_B, qenc_pkg::PINS_BOTH);
		send_event(qenc_pkg::CHAN_A, qenc_pkg::PINS_B_ONLY);
		send_event(qenc_pkg::CHAN_B, qenc_pkg::PINS_A_ONLY);
	endtask

	task automatic test_detents_default();
		detent_up();
		detent_down();
	endtask

	// widest limits, largest step; out-of-range register index is ignored
	task automatic test_full_scale();
		configure(16'h8000, 16'h7FFF, 16'hFFFF);
		write_reg(REG_UNUSED, 16'h0000);
		write_reg(REG_UNUSED, 16'hFFFF);
		detent_up();
		detent_down();
		detent_down();
		detent_down();
	endtask

	// count left outside the limits, then inverted limits, all with zero step
	task automatic test_limits_outside();
		configure(16'd100, 16'd200, 16'd0);
		detent_down();
		write_reg(qenc_pkg::REG_HIGH_LIMIT, 16'd50);
		detent_up();
		detent_down();
		detent_up();
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		int pick;
		int up_bias;
		int lo;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					configure(16'h8000, 16'h7FFF, 16'h7FFF);
				end
				1: begin
					configure(16'(-int'($urandom_range(0, 60))), 16'($urandom_range(0, 60)),
						16'($urandom_range(1, 6)));
				end
				2: begin
					lo = $urandom_range(10, 80);
					configure(16'(lo), 16'(lo - int'($urandom_range(1, 40))),
						16'($urandom_range(1, 4)));
				end
				3: begin
					configure(16'(-int'($urandom_range(0, 20))), 16'($urandom_range(0, 20)),
						16'h0000);
				end
				4: begin
					configure(16'($urandom), 16'($urandom), 16'($urandom));
					write_reg(REG_UNUSED, 16'($urandom));
				end
				default: begin
					lo = int'($urandom_range(0, 60)) - 30;
					configure(16'(lo), 16'(lo), 16'($urandom_range(1, 3)));
				end
			endcase
			no_gaps = (phase == 2);
			up_bias = $urandom_range(25, 75);
			n = 0;
			while (n < PHASE_ITEMS) begin
				// hold off mid-stream once until the pipe is empty
				if (phase == 3 && n == PHASE_ITEMS / 2)
					wait_drained();
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					if ($urandom_range(0, 99) < up_bias)
						detent_up();
					else
						detent_down();
					n += 2;
				end else begin
					send_event(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
					n++;
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// result side: random stalls, with the stall rate redrawn after each span of random length
	initial begin : result_sink
		int stall_left;
		int stall_pct;
		int span;
		stall_left = 0;
		stall_pct  = 0;
		span       = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = $urandom_range(100, 400);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			span--;
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	qenc_pkg::res_t want;

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= MAX_REPORTS)
					$display("%0t unexpected result beat: position %0d movement %0d",
						$time, res_bus.position, res_bus.movement);
			end else begin
				want = pending_results.pop_front();
				if (res_bus.position !== want.position) begin
					fault_cnt++;
					if (fault_cnt <= MAX_REPORTS)
						$display("%0t position mismatch: expected %0d, actual %0d",
							$time, want.position, res_bus.position);
				end
				if (res_bus.movement !== want.movement) begin
					fault_cnt++;
					if (fault_cnt <= MAX_REPORTS)
						$display("%0t movement mismatch: expected %0d, actual %0d",
							$time, want.movement, res_bus.movement);
				end
			end
		end
	end

	// ends the run when no channel moves a beat for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : main_seq
		evt_bus.valid      <= 1'b0;
		evt_bus.command    <= qenc_pkg::CHAN_A;
		evt_bus.pin_levels <= 2'b00;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= qenc_pkg::REG_LOW_LIMIT;
		cfg_bus.data       <= 16'h0000;
		arst_n             <= 1'b0;
		shadow_cfg.low_limit  = qenc_pkg::LOW_LIMIT_RST;
		shadow_cfg.high_limit = qenc_pkg::HIGH_LIMIT_RST;
		shadow_cfg.step_size  = qenc_pkg::STEP_SIZE_RST;
		arm_up    = 1'b0;
		arm_down  = 1'b0;
		enc_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_rule_events();
		test_detents_default();
		test_full_scale();
		test_limits_outside();
		test_random_traffic();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### quadrature_encoder_clamped_position_unit.f
rtl/qenc_pkg.sv
rtl/qenc_ifs.sv
rtl/qenc_cfg_regs.sv
rtl/qenc_update.sv
rtl/quadrature_encoder_clamped_position_unit.sv
rtl/qenc_checker.sv
verif/tb_quadrature_encoder_clamped_position_unit.sv
